[rtl/core/hybrid_branch_predictor_macros.svh]
// Assertion helpers shared by the branch predictor RTL.
// Each check is sampled on the rising clock edge and disabled while in reset.
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication check
`define HBP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hybrid_branch_predictor: same-cycle check failed");

// Next-cycle implication check
`define HBP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hybrid_branch_predictor: next-cycle check failed");

`endif

[rtl/core/hbp_pkg.sv]
package hbp_pkg;

  // 2-bit saturating counter
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN      = 2'd0;
  localparam ctr_t CTR_MAX      = 2'd3;
  localparam ctr_t CTR_WEAK_TKN = 2'd2;  // reset value of both predictor tables
  localparam ctr_t CTR_WEAK_BIM = 2'd1;  // reset value of the chooser table

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIM_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GSH_BITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHO_BITS  = 3'd4;

  // Predictor modes; the fourth code behaves as hybrid
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // Register reset values
  localparam logic [1:0]            RST_MODE      = MODE_BIMODAL;
  localparam logic [CFG_DATA_W-1:0] RST_BIM_BITS  = 4'd12;
  localparam logic [CFG_DATA_W-1:0] RST_GSH_BITS  = 4'd12;
  localparam logic [CFG_DATA_W-1:0] RST_HIST_BITS = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_CHO_BITS  = 4'd12;

  // Table update request from the predict stage
  typedef struct packed {
    logic bim_we;
    ctr_t bim_val;
    logic gsh_we;
    ctr_t gsh_val;
    logic cho_we;
    ctr_t cho_val;
  } upd_t;

  // One result transaction
  typedef struct packed {
    logic prediction;
    logic mispredicted;
    logic used_gshare;
  } res_t;

  // Saturating step toward the outcome
  function automatic ctr_t ctr_train(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/core/hbp_ctr_mem.sv]
module hbp_ctr_mem #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hbp_pkg::ctr_t wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output hbp_pkg::ctr_t rdata_o
);
  import hbp_pkg::*;

  ctr_t mem_q [2**AW];
  ctr_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hbp_index.sv]
module hbp_index #(
  parameter int unsigned IDX_MAX  = 12,
  parameter int unsigned PC_WIDTH = 24
) (
  input  logic [PC_WIDTH-3:0]          word_i,      // pc[PC_WIDTH-1:2]
  input  logic [hbp_pkg::CFG_DATA_W-1:0] width_i,   // raw index width register
  input  logic [IDX_MAX-1:0]           hist_i,      // newest outcome at MSB
  input  logic [hbp_pkg::CFG_DATA_W-1:0] hist_len_i,
  output logic [IDX_MAX-1:0]           idx_o
);
  import hbp_pkg::*;

  localparam int unsigned IW   = $clog2(IDX_MAX + 1);
  localparam int unsigned WEXT = (IDX_MAX > PC_WIDTH - 2) ? IDX_MAX : PC_WIDTH - 2;

  logic [IW-1:0]      w;
  logic [IW-1:0]      nh;
  logic [WEXT-1:0]    word_ext;
  logic [IDX_MAX-1:0] hist_al;
  logic [IDX_MAX-1:0] in_rng;
  logic [IDX_MAX-1:0] hist_sel;

  // Clamp index width to [1, IDX_MAX] and history length to the width
  always_comb begin
    if (width_i == '0) begin
      w = IW'(1);
    end else if (int'(width_i) > int'(IDX_MAX)) begin
      w = IW'(IDX_MAX);
    end else begin
      w = IW'(width_i);
    end
    if (int'(hist_len_i) < int'(w)) begin
      nh = IW'(hist_len_i);
    end else begin
      nh = w;
    end
  end

  // Pc bits beyond the pc width read as zero
  assign word_ext = WEXT'(word_i);

  // Line the history up so its MSB meets the index MSB
  assign hist_al = hist_i >> (int'(IDX_MAX) - int'(w));

  // Per-bit mask and XOR of the top nh index bits
  always_comb begin
    for (int k = 0; k < int'(IDX_MAX); k++) begin
      in_rng[k]   = k < int'(w);
      hist_sel[k] = (k + int'(nh)) >= int'(w);
      idx_o[k]    = in_rng[k] & (word_ext[k] ^ (hist_sel[k] & hist_al[k]));
    end
  end

endmodule

[rtl/core/hbp_predict.sv]
module hbp_predict (
  input  logic          [1:0] mode_i,
  input  logic                taken_i,
  input  hbp_pkg::ctr_t       bim_ctr_i,
  input  hbp_pkg::ctr_t       gsh_ctr_i,
  input  hbp_pkg::ctr_t       cho_ctr_i,
  output hbp_pkg::res_t       res_o,
  output hbp_pkg::upd_t       upd_o
);
  import hbp_pkg::*;

  logic bpred;
  logic gpred;
  logic use_g;
  logic hybrid;
  logic b_ok;
  logic g_ok;
  logic pred;

  assign bpred = bim_ctr_i[1];
  assign gpred = gsh_ctr_i[1];
  assign b_ok  = bpred == taken_i;
  assign g_ok  = gpred == taken_i;

  // Predictor selection
  always_comb begin
    unique case (mode_i)
      MODE_BIMODAL: begin
        use_g  = 1'b0;
        hybrid = 1'b0;
      end
      MODE_GSHARE: begin
        use_g  = 1'b1;
        hybrid = 1'b0;
      end
      default: begin
        use_g  = cho_ctr_i[1];
        hybrid = 1'b1;
      end
    endcase
  end

  assign pred = use_g ? gpred : bpred;

  assign res_o.prediction   = pred;
  assign res_o.mispredicted = pred != taken_i;
  assign res_o.used_gshare  = use_g;

  // Only the chosen predictor trains; in hybrid mode the chooser moves when exactly one was right
  assign upd_o.bim_we  = !use_g;
  assign upd_o.bim_val = ctr_train(bim_ctr_i, taken_i);
  assign upd_o.gsh_we  = use_g;
  assign upd_o.gsh_val = ctr_train(gsh_ctr_i, taken_i);
  assign upd_o.cho_we  = hybrid && (g_ok != b_ok);
  assign upd_o.cho_val = ctr_train(cho_ctr_i, g_ok);

endmodule

[rtl/core/hybrid_branch_predictor.sv]
// Bimodal / gshare / tournament branch predictor built on 2-bit saturating
// counters. One branch (pc, actual outcome) is taken per clock while
// in_ready_o is high. The tables are read at the edge that accepts a branch;
// its result (prediction, mispredicted, used_gshare) and the table write-back
// are registered when stage 1 advances, which waits while a held result is
// not taken by out_ready_i. A new branch may follow in every cycle unless the
// output stalls. The counter tables are single-port-write, single-port-read
// RAMs read at accept time; a write from the previous branch to the same entry
// is forwarded. After reset the block sweeps every table entry, writing reset
// values, and holds in_ready_o low meanwhile; configuration writes are taken at
// any time but should only be issued while no branch is in flight.
`include "hybrid_branch_predictor_macros.svh"

module hybrid_branch_predictor #(
  parameter int unsigned BIMODAL_MAX_BITS = 12,
  parameter int unsigned GSHARE_MAX_BITS  = 12,
  parameter int unsigned CHOOSER_MAX_BITS = 12,
  parameter int unsigned PC_WIDTH         = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // branch input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [PC_WIDTH-1:0]              pc_i,
  input  logic                             taken_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             prediction_o,
  output logic                             mispredicted_o,
  output logic                             used_gshare_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hbp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hbp_pkg::*;

  localparam int unsigned BW = BIMODAL_MAX_BITS;
  localparam int unsigned GW = GSHARE_MAX_BITS;
  localparam int unsigned CW = CHOOSER_MAX_BITS;
  localparam int unsigned BG_MAX = (BW > GW) ? BW : GW;
  localparam int unsigned CLR_W  = (BG_MAX > CW) ? BG_MAX : CW;

  // Config registers
  logic [1:0]            mode_q;
  logic [CFG_DATA_W-1:0] bim_bits_q, gsh_bits_q, hist_bits_q, cho_bits_q;

  // Control
  logic             clr_q;
  logic [CLR_W-1:0] clr_cnt_q;
  logic             in_accept;
  logic             s1_adv;
  logic             s1_valid_q;
  logic             out_valid_q;

  // History and stage-1 payload
  logic [GW-1:0] hist_q;
  logic          s1_taken_q;
  logic [BW-1:0] s1_bidx_q;
  logic [GW-1:0] s1_gidx_q;
  logic [CW-1:0] s1_cidx_q;

  // Indices for the incoming branch
  logic [BW-1:0] bidx;
  logic [GW-1:0] gidx;
  logic [CW-1:0] cidx;

  // Table ports
  logic          bim_we, gsh_we, cho_we;
  logic [BW-1:0] bim_waddr;
  logic [GW-1:0] gsh_waddr;
  logic [CW-1:0] cho_waddr;
  ctr_t          bim_wdata, gsh_wdata, cho_wdata;
  ctr_t          bim_rdata, gsh_rdata, cho_rdata;

  // Last write to each table, for forwarding
  logic          lwb_valid_q, lwg_valid_q, lwc_valid_q;
  logic [BW-1:0] lwb_addr_q;
  logic [GW-1:0] lwg_addr_q;
  logic [CW-1:0] lwc_addr_q;
  ctr_t          lwb_data_q, lwg_data_q, lwc_data_q;

  ctr_t bim_ctr, gsh_ctr, cho_ctr;
  res_t res;
  upd_t upd;
  res_t out_res_q;

  // Handshakes
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !clr_q && (!s1_valid_q || s1_adv);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RST_MODE;
      bim_bits_q  <= RST_BIM_BITS;
      gsh_bits_q  <= RST_GSH_BITS;
      hist_bits_q <= RST_HIST_BITS;
      cho_bits_q  <= RST_CHO_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      mode_q      <= cfg_data_i[1:0];
        CFG_BIM_BITS:  bim_bits_q  <= cfg_data_i;
        CFG_GSH_BITS:  gsh_bits_q  <= cfg_data_i;
        CFG_HIST_BITS: hist_bits_q <= cfg_data_i;
        CFG_CHO_BITS:  cho_bits_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Index generation
  hbp_index #(.IDX_MAX(BW), .PC_WIDTH(PC_WIDTH)) u_bim_index (
    .word_i     (pc_i[PC_WIDTH-1:2]),
    .width_i    (bim_bits_q),
    .hist_i     ('0),
    .hist_len_i ('0),
    .idx_o      (bidx)
  );

  hbp_index #(.IDX_MAX(GW), .PC_WIDTH(PC_WIDTH)) u_gsh_index (
    .word_i     (pc_i[PC_WIDTH-1:2]),
    .width_i    (gsh_bits_q),
    .hist_i     (hist_q),
    .hist_len_i (hist_bits_q),
    .idx_o      (gidx)
  );

  hbp_index #(.IDX_MAX(CW), .PC_WIDTH(PC_WIDTH)) u_cho_index (
    .word_i     (pc_i[PC_WIDTH-1:2]),
    .width_i    (cho_bits_q),
    .hist_i     ('0),
    .hist_len_i ('0),
    .idx_o      (cidx)
  );

  // Write port muxing: clearing sweep or stage-1 training
  assign bim_we    = clr_q || (s1_adv && upd.bim_we);
  assign bim_waddr = clr_q ? clr_cnt_q[BW-1:0] : s1_bidx_q;
  assign bim_wdata = clr_q ? CTR_WEAK_TKN : upd.bim_val;
  assign gsh_we    = clr_q || (s1_adv && upd.gsh_we);
  assign gsh_waddr = clr_q ? clr_cnt_q[GW-1:0] : s1_gidx_q;
  assign gsh_wdata = clr_q ? CTR_WEAK_TKN : upd.gsh_val;
  assign cho_we    = clr_q || (s1_adv && upd.cho_we);
  assign cho_waddr = clr_q ? clr_cnt_q[CW-1:0] : s1_cidx_q;
  assign cho_wdata = clr_q ? CTR_WEAK_BIM : upd.cho_val;

  hbp_ctr_mem #(.AW(BW)) u_bim_mem (
    .clk_i   (clk_i),
    .we_i    (bim_we),
    .waddr_i (bim_waddr),
    .wdata_i (bim_wdata),
    .re_i    (in_accept),
    .raddr_i (bidx),
    .rdata_o (bim_rdata)
  );

  hbp_ctr_mem #(.AW(GW)) u_gsh_mem (
    .clk_i   (clk_i),
    .we_i    (gsh_we),
    .waddr_i (gsh_waddr),
    .wdata_i (gsh_wdata),
    .re_i    (in_accept),
    .raddr_i (gidx),
    .rdata_o (gsh_rdata)
  );

  hbp_ctr_mem #(.AW(CW)) u_cho_mem (
    .clk_i   (clk_i),
    .we_i    (cho_we),
    .waddr_i (cho_waddr),
    .wdata_i (cho_wdata),
    .re_i    (in_accept),
    .raddr_i (cidx),
    .rdata_o (cho_rdata)
  );

  // Stage-1 control, history, result valid and last-write valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      lwb_valid_q <= 1'b0;
      lwg_valid_q <= 1'b0;
      lwc_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        hist_q     <= {taken_i, hist_q[GW-1:1]};
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && upd.bim_we) lwb_valid_q <= 1'b1;
      if (s1_adv && upd.gsh_we) lwg_valid_q <= 1'b1;
      if (s1_adv && upd.cho_we) lwc_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_taken_q <= taken_i;
      s1_bidx_q  <= bidx;
      s1_gidx_q  <= gidx;
      s1_cidx_q  <= cidx;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
    if (s1_adv && upd.bim_we) begin
      lwb_addr_q <= s1_bidx_q;
      lwb_data_q <= upd.bim_val;
    end
    if (s1_adv && upd.gsh_we) begin
      lwg_addr_q <= s1_gidx_q;
      lwg_data_q <= upd.gsh_val;
    end
    if (s1_adv && upd.cho_we) begin
      lwc_addr_q <= s1_cidx_q;
      lwc_data_q <= upd.cho_val;
    end
  end

  // Forward the previous branch's write, which the RAM read missed
  assign bim_ctr = (lwb_valid_q && lwb_addr_q == s1_bidx_q) ? lwb_data_q : bim_rdata;
  assign gsh_ctr = (lwg_valid_q && lwg_addr_q == s1_gidx_q) ? lwg_data_q : gsh_rdata;
  assign cho_ctr = (lwc_valid_q && lwc_addr_q == s1_cidx_q) ? lwc_data_q : cho_rdata;

  hbp_predict u_predict (
    .mode_i    (mode_q),
    .taken_i   (s1_taken_q),
    .bim_ctr_i (bim_ctr),
    .gsh_ctr_i (gsh_ctr),
    .cho_ctr_i (cho_ctr),
    .res_o     (res),
    .upd_o     (upd)
  );

  assign out_valid_o    = out_valid_q;
  assign prediction_o   = out_res_q.prediction;
  assign mispredicted_o = out_res_q.mispredicted;
  assign used_gshare_o  = out_res_q.used_gshare;

  // Checks
  `HBP_ASSERT_IMP(a_no_accept_in_clear, clr_q, !in_ready_o)
  `HBP_ASSERT_NXT(a_s1_holds_on_stall, s1_valid_q && !s1_adv, s1_valid_q)
  `HBP_ASSERT_NXT(a_adv_fills_out, s1_adv, out_valid_o)
  `HBP_ASSERT_NXT(a_bimodal_mode_src, s1_adv && mode_q == MODE_BIMODAL, !used_gshare_o)
  `HBP_ASSERT_NXT(a_gshare_mode_src, s1_adv && mode_q == MODE_GSHARE, used_gshare_o)

endmodule
